### sv/crf_pkg.sv
// shared types and constants for the console receive framer
// no dependencies; compiled first
package crf_pkg;

  localparam int BUF_DEPTH_DEF = 64;

  localparam logic [7:0]  CHAR_CR      = 8'h0D;
  localparam logic [7:0]  CHAR_LF      = 8'h0A;
  localparam int          FRAME_HEADER = 2;

  localparam logic [15:0] TIMEOUT_RST    = 16'd10;
  localparam logic [7:0]  START_CODE_RST = 8'h01;

  localparam int APB_AW = 3;

  // register index taken from paddr[2]
  typedef enum logic {
    REG_TIMEOUT    = 1'b0,
    REG_START_CODE = 1'b1
  } crf_reg_t;

  typedef struct packed {
    logic [15:0] timeout_ms;
    logic [7:0]  binary_start_code;
  } crf_cfg_t;

endpackage

### sv/crf_if.sv
// valid/ready channel interfaces for the framer input and result streams
// no dependencies
interface crf_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  rx_byte;
  logic [31:0] now_ms;

  modport source (output valid, req_type, rx_byte, now_ms, input ready);
  modport sink   (input valid, req_type, rx_byte, now_ms, output ready);
endinterface

interface crf_out_if;
  logic       valid;
  logic       ready;
  logic       store_valid;
  logic [5:0] store_index;
  logic [7:0] store_byte;
  logic       message_ready;
  logic       in_binary;
  logic       pending_warning;
  logic [6:0] fill_count;

  modport source (output valid, store_valid, store_index, store_byte, message_ready,
                  in_binary, pending_warning, fill_count, input ready);
  modport sink   (input valid, store_valid, store_index, store_byte, message_ready,
                  in_binary, pending_warning, fill_count, output ready);
endinterface

### sv/crf_regs.sv
// apb configuration registers: idle timeout and binary start code
// depends on crf_pkg
module crf_regs (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [crf_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output crf_pkg::crf_cfg_t          cfg
);
  import crf_pkg::*;

  logic     wr_en;
  crf_reg_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign sel    = crf_reg_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ms        <= TIMEOUT_RST;
      cfg.binary_start_code <= START_CODE_RST;
    end else if (wr_en) begin
      case (sel)
        REG_TIMEOUT:    cfg.timeout_ms        <= pwdata[15:0];
        REG_START_CODE: cfg.binary_start_code <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_TIMEOUT:    prdata = {16'd0, cfg.timeout_ms};
      REG_START_CODE: prdata = {24'd0, cfg.binary_start_code};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

### sv/crf_framer.sv
// framing datapath: input register, per-byte framing logic and state, result register
// depends on crf_pkg and crf_if
module crf_framer #(
  parameter int BUF_DEPTH = crf_pkg::BUF_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  crf_pkg::crf_cfg_t cfg,
  crf_in_if.sink            in_ch,
  crf_out_if.source         out_ch
);
  import crf_pkg::*;

  localparam int IW    = $clog2(BUF_DEPTH + 1);
  localparam int CMP_W = (IW > 8 ? IW : 8) + 1;

  // input register
  logic        s1_valid;
  logic        s1_req;
  logic [7:0]  s1_byte;
  logic [31:0] s1_now;
  logic        advance;

  // framing state
  logic [IW-1:0] write_index, write_index_next;
  logic          binary_active, binary_active_next;
  logic [31:0]   last_byte_time, last_byte_time_next;
  logic [7:0]    length_field, length_field_next;
  logic          ready_flag, ready_flag_next;

  logic          stored;
  logic          warn;
  logic [IW-1:0] pos;
  logic [IW-1:0] wi;
  logic          timed_out;
  logic [31:0]   pos_ext;
  logic [31:0]   wi_ext;

  assign advance     = s1_valid && (!out_ch.valid || out_ch.ready);
  assign in_ch.ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_req  <= in_ch.req_type;
      s1_byte <= in_ch.rx_byte;
      s1_now  <= in_ch.now_ms;
    end
  end

  assign timed_out = (s1_now - last_byte_time) > {16'd0, cfg.timeout_ms};

  always_comb begin
    write_index_next    = write_index;
    binary_active_next  = binary_active;
    last_byte_time_next = last_byte_time;
    length_field_next   = length_field;
    ready_flag_next     = ready_flag;
    stored              = 1'b0;
    warn                = 1'b0;
    pos                 = '0;
    wi                  = write_index;

    if (s1_req) begin
      // consume transaction
      write_index_next = '0;
      ready_flag_next  = 1'b0;
    end else begin
      warn = ready_flag;
      if (binary_active && timed_out) begin
        binary_active_next = 1'b0;
        wi                 = '0;
      end
      last_byte_time_next = s1_now;
      if (wi == '0) begin
        binary_active_next = (s1_byte == cfg.binary_start_code);
      end
      write_index_next = wi;

      if (binary_active_next) begin
        if (wi < IW'(BUF_DEPTH)) begin
          stored = 1'b1;
          pos    = wi;
          if (wi == IW'(1)) begin
            length_field_next = s1_byte;
          end
          if (CMP_W'(wi) > CMP_W'(FRAME_HEADER) &&
              CMP_W'(wi) == CMP_W'(length_field) + CMP_W'(FRAME_HEADER)) begin
            ready_flag_next = 1'b1;
          end
          write_index_next = wi + IW'(1);
        end
      end else begin
        if (s1_byte == CHAR_CR) begin
          // carriage return ignored
        end else if (s1_byte == CHAR_LF) begin
          ready_flag_next = 1'b1;
        end else if (wi < IW'(BUF_DEPTH)) begin
          stored           = 1'b1;
          pos              = wi;
          write_index_next = wi + IW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index    <= '0;
      binary_active  <= 1'b0;
      last_byte_time <= '0;
      ready_flag     <= 1'b0;
    end else if (advance) begin
      write_index    <= write_index_next;
      binary_active  <= binary_active_next;
      last_byte_time <= last_byte_time_next;
      ready_flag     <= ready_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      length_field <= length_field_next;
    end
  end

  assign pos_ext = 32'(pos);
  assign wi_ext  = 32'(write_index_next);

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (advance) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_ch.store_valid     <= stored;
      out_ch.store_index     <= pos_ext[5:0];
      out_ch.store_byte      <= stored ? s1_byte : 8'd0;
      out_ch.message_ready   <= ready_flag_next;
      out_ch.in_binary       <= binary_active_next;
      out_ch.pending_warning <= warn;
      out_ch.fill_count      <= wi_ext[6:0];
    end
  end

endmodule

### sv/console_rx_framer.sv
// console receive framer top level: apb registers plus framing datapath
// depends on crf_pkg, crf_if, crf_regs and crf_framer
//
// in_ch carries one transaction per received byte (req_type 0, rx_byte,
// now_ms) or per consume notice (req_type 1). out_ch returns exactly one
// transaction per input: the buffer write, if any, plus ready, mode,
// warning and fill count after that input.
// a result is captured by the input register when its input is accepted,
// and then by the result register once out_ch can take it.
// throughput: one transaction per cycle while out_ch does not stall; the
// framing state loop closes in the single logic stage between the two registers.
// when out_ch stalls the result register holds, the input register takes one more
// transaction only if it is empty, and in_ch.ready then stays low until out_ch moves.
// reset clears the index, mode, ready flag and timestamp, loads the
// timeout (10 ms) and start code (0x01), and empties both registers.
// the apb port takes timeout_ms at 0x0 and binary_start_code at 0x4;
// write it only while no transaction is in flight.
module console_rx_framer #(
  parameter int BUF_DEPTH = crf_pkg::BUF_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [crf_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  crf_in_if.sink                     in_ch,
  crf_out_if.source                  out_ch
);
  import crf_pkg::*;

  crf_cfg_t cfg;

  crf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  crf_framer #(
    .BUF_DEPTH (BUF_DEPTH)
  ) u_framer (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

endmodule
